FILE: design/hsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsd_pkg
// Shared sizes, byte codes, error codes and beat types of the Huffman
// stream decoder.
// ----------------------------------------------------------------------------
package hsd_pkg;

  // Table sizes
  localparam int MAX_NODES = 512;
  localparam int MAX_DEPTH = 256;

  // Node index, node count, stack index and stack count widths
  localparam int NODE_W  = $clog2(MAX_NODES);
  localparam int CNT_W   = $clog2(MAX_NODES + 1);
  localparam int DEPTH_W = $clog2(MAX_DEPTH);
  localparam int TOP_W   = $clog2(MAX_DEPTH + 1);

  // ASCII bytes with a special meaning in the stream
  localparam logic [7:0] BYTE_ONE  = 8'h31;
  localparam logic [7:0] BYTE_ZERO = 8'h30;

  // Error codes of a result beat
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_NODES = 2'd1;
  localparam logic [1:0] ERR_STACK = 2'd2;

  // Input beat
  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_file;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic [7:0] symbol;
    logic       is_last;
    logic [1:0] error;
  } out_beat_t;

  // Node table entry; the left child of an internal node n is n + 1
  typedef struct packed {
    logic              leaf;
    logic [7:0]        sym;
    logic [NODE_W-1:0] right;
  } node_t;

endpackage : hsd_pkg
`default_nettype wire

FILE: design/huffman_stream_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_stream_decoder
// Byte-stream Huffman decoder: symbol count, preorder tree rebuild into a
// node table, then one code bit per byte.
// ----------------------------------------------------------------------------
// Every input byte passes through steps s1 and s2; a new one is taken only as
// the previous one finishes, so bytes do not overlap. Step s1 reads
// the single-port synchronous memories (the pending-slot stack while the tree
// is built, the node table at the next child while decoding) and writes the
// new node entry; step s2 uses the registered read data, writes the
// parent's right-child link and the stack, and updates the parse state.
// Results pass through one output register, so a waiting result does not
// hold up the next byte unless that byte also has a result to deliver.
// Neither memory needs clearing after reset: only written entries are read.
// Left children are implicit in preorder, so only right links are stored.
module huffman_stream_decoder
  import hsd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_beat_t  in_beat,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_beat_t      out_beat
);

  typedef enum logic [2:0] {
    PH_COUNT,
    PH_TAG,
    PH_SYM,
    PH_DECODE,
    PH_DONE,
    PH_HALT
  } phase_t;

  // Memories
  node_t             node_mem  [MAX_NODES];
  logic [NODE_W-1:0] stack_mem [MAX_DEPTH];

  // Pipeline control
  logic      s1_r, s1_nxt;
  logic      s2_r, s2_nxt;
  logic      finish, accept;
  in_beat_t  in_r;

  // Parse state
  phase_t             phase_r, phase_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic [31:0]        rem_r, rem_nxt;
  logic [CNT_W-1:0]   nodes_r, nodes_nxt;
  logic [TOP_W-1:0]   top_r, top_nxt;
  logic [NODE_W-1:0]  leaf_wait_r, leaf_wait_nxt;
  logic [NODE_W-1:0]  walk_r, walk_nxt;
  logic               last_int_r, last_int_nxt;
  logic               at_root_r, at_root_nxt;
  node_t              cur_r, cur_nxt;
  node_t              root_r;

  // Output register
  logic       out_valid_r, out_valid_nxt;
  out_beat_t  out_beat_r, out_beat_nxt;

  // State as seen by the beat in flight, after a start-of-file clear
  phase_t             e_phase;
  logic [1:0]         e_cnt;
  logic [31:0]        e_rem;
  logic [CNT_W-1:0]   e_nodes;
  logic [TOP_W-1:0]   e_top;
  logic [NODE_W-1:0]  e_leaf_wait;
  logic [NODE_W-1:0]  e_walk;
  logic               e_last_int;
  logic               e_at_root;

  // Tree build and walk decode terms
  logic               is_one;
  logic [NODE_W-1:0]  n_idx;
  logic               tbl_full;
  logic               do_pop;
  logic [TOP_W-1:0]   avail;
  logic               stk_full;
  logic               tag_ok;
  logic               pop_right;
  node_t              cur_node;
  logic [NODE_W:0]    step;
  logic [NODE_W-1:0]  next_idx;
  logic [31:0]        rem_dec;
  logic               res_due;

  // Memory ports
  logic               nr_en;
  logic [NODE_W-1:0]  nr_addr;
  node_t              node_rd_r;
  logic               nw_full, nw_sym, nw_right;
  logic [NODE_W-1:0]  nw_addr;
  node_t              nw_data;
  logic               sr_en;
  logic [NODE_W-1:0]  stack_rd_r;
  logic               sw_en;
  logic [DEPTH_W-1:0] stk_addr;

  // Handshake: take a beat when idle or as the current one finishes;
  // only a beat with a result waits for the output register
  assign finish    = s2_r && (!res_due || !out_valid_r || !out_stall);
  assign in_stall  = s1_r || (s2_r && !finish);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  // Apply start-of-file clear to the view of the state
  always_comb begin
    if (in_r.start_of_file) begin
      e_phase     = PH_COUNT;
      e_cnt       = '0;
      e_rem       = '0;
      e_nodes     = '0;
      e_top       = '0;
      e_leaf_wait = '0;
      e_walk      = '0;
      e_last_int  = 1'b0;
      e_at_root   = 1'b1;
    end else begin
      e_phase     = phase_r;
      e_cnt       = cnt_r;
      e_rem       = rem_r;
      e_nodes     = nodes_r;
      e_top       = top_r;
      e_leaf_wait = leaf_wait_r;
      e_walk      = walk_r;
      e_last_int  = last_int_r;
      e_at_root   = at_root_r;
    end
  end

  // Tree tag checks and walk step
  always_comb begin
    is_one    = (in_r.in_byte == BYTE_ONE);
    n_idx     = e_nodes[NODE_W-1:0];
    tbl_full  = (e_nodes >= CNT_W'(MAX_NODES));
    do_pop    = (e_nodes != '0) && (e_top != '0);
    avail     = do_pop ? (e_top - TOP_W'(1)) : e_top;
    stk_full  = is_one && (({1'b0, avail} + (TOP_W+1)'(2)) > (TOP_W+1)'(MAX_DEPTH));
    tag_ok    = !tbl_full && !stk_full;
    // a side-0 slot on top is the left child, which needs no link
    pop_right = do_pop && !e_last_int;
    stk_addr  = avail[DEPTH_W-1:0];
    cur_node  = e_at_root ? root_r : cur_r;
    if (in_r.in_byte == BYTE_ZERO) begin
      step = {1'b0, e_walk} + (NODE_W+1)'(1);
    end else begin
      step = {1'b0, cur_node.right};
    end
    if (step >= (NODE_W+1)'(MAX_NODES)) begin
      next_idx = '0;
    end else begin
      next_idx = step[NODE_W-1:0];
    end
    rem_dec = e_rem - 32'd1;
    // the beat in its s2 step owes a result
    res_due = ((e_phase == PH_TAG) && !tag_ok) ||
              ((e_phase == PH_DECODE) && (cur_node.leaf || node_rd_r.leaf));
  end

  // Memory port control: reads and node writes in step s1,
  // parent link and stack push in step s2
  always_comb begin
    nr_en    = s1_r && (e_phase == PH_DECODE) && !cur_node.leaf;
    nr_addr  = next_idx;
    sr_en    = s1_r && (e_phase == PH_TAG) && tag_ok && pop_right;
    sw_en    = finish && (e_phase == PH_TAG) && tag_ok && is_one;
    nw_full  = 1'b0;
    nw_sym   = 1'b0;
    nw_right = 1'b0;
    nw_addr  = n_idx;
    nw_data  = '{leaf: !is_one, sym: 8'd0, right: '0};
    if (s1_r && (e_phase == PH_TAG) && tag_ok) begin
      nw_full = 1'b1;
    end else if (s1_r && (e_phase == PH_SYM)) begin
      nw_sym       = 1'b1;
      nw_addr      = e_leaf_wait;
      nw_data.sym  = in_r.in_byte;
    end else if (finish && (e_phase == PH_TAG) && tag_ok && pop_right) begin
      nw_right      = 1'b1;
      nw_addr       = stack_rd_r;
      nw_data.right = n_idx;
    end
  end

  // Node table: masked write, registered read
  always_ff @(posedge clk) begin
    if (nw_full) begin
      node_mem[nw_addr] <= nw_data;
    end else begin
      if (nw_sym) begin
        node_mem[nw_addr].sym <= nw_data.sym;
      end
      if (nw_right) begin
        node_mem[nw_addr].right <= nw_data.right;
      end
    end
    if (nr_en) begin
      node_rd_r <= node_mem[nr_addr];
    end
  end

  // Pending-slot stack: holds parents still waiting for a right child
  always_ff @(posedge clk) begin
    if (sw_en) begin
      stack_mem[stk_addr] <= n_idx;
    end
    if (sr_en) begin
      stack_rd_r <= stack_mem[stk_addr];
    end
  end

  // Mirror the root entry so a walk can restart without a read
  always_ff @(posedge clk) begin
    if (nw_addr == '0) begin
      if (nw_full) begin
        root_r <= nw_data;
      end else begin
        if (nw_sym) begin
          root_r.sym <= nw_data.sym;
        end
        if (nw_right) begin
          root_r.right <= nw_data.right;
        end
      end
    end
  end

  // Next parse state and result of the finishing beat
  always_comb begin
    s1_nxt        = accept;
    s2_nxt        = s1_r || (s2_r && !finish);
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    nodes_nxt     = nodes_r;
    top_nxt       = top_r;
    leaf_wait_nxt = leaf_wait_r;
    walk_nxt      = walk_r;
    last_int_nxt  = last_int_r;
    at_root_nxt   = at_root_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_beat_nxt  = out_beat_r;
    if (finish) begin
      phase_nxt     = e_phase;
      cnt_nxt       = e_cnt;
      rem_nxt       = e_rem;
      nodes_nxt     = e_nodes;
      top_nxt       = e_top;
      leaf_wait_nxt = e_leaf_wait;
      walk_nxt      = e_walk;
      last_int_nxt  = e_last_int;
      at_root_nxt   = e_at_root;
      case (e_phase)
        PH_COUNT: begin
          rem_nxt = e_rem | (32'(in_r.in_byte) << {e_cnt, 3'b000});
          cnt_nxt = e_cnt + 2'd1;
          if (e_cnt == 2'd3) begin
            phase_nxt = PH_TAG;
          end
        end
        PH_TAG: begin
          if (!tag_ok) begin
            phase_nxt     = PH_HALT;
            out_valid_nxt = 1'b1;
            out_beat_nxt  = '{symbol: 8'd0, is_last: 1'b0,
                              error: tbl_full ? ERR_NODES : ERR_STACK};
          end else begin
            nodes_nxt    = e_nodes + CNT_W'(1);
            last_int_nxt = is_one;
            if (is_one) begin
              top_nxt = avail + TOP_W'(2);
            end else begin
              top_nxt       = avail;
              leaf_wait_nxt = n_idx;
              phase_nxt     = PH_SYM;
            end
          end
        end
        PH_SYM: begin
          if (e_top == '0) begin
            walk_nxt    = '0;
            at_root_nxt = 1'b1;
            if ((e_rem == 32'd0) || e_rem[31]) begin
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_DECODE;
            end
          end else begin
            phase_nxt = PH_TAG;
          end
        end
        PH_DECODE: begin
          if (cur_node.leaf || node_rd_r.leaf) begin
            rem_nxt       = rem_dec;
            walk_nxt      = '0;
            at_root_nxt   = 1'b1;
            out_valid_nxt = 1'b1;
            out_beat_nxt  = '{symbol: cur_node.leaf ? cur_node.sym : node_rd_r.sym,
                              is_last: (rem_dec == 32'd0), error: ERR_NONE};
            if (rem_dec == 32'd0) begin
              phase_nxt = PH_DONE;
            end
          end else begin
            cur_nxt     = node_rd_r;
            walk_nxt    = next_idx;
            at_root_nxt = 1'b0;
          end
        end
        default: begin
          // done or halted: drop the byte
        end
      endcase
    end
  end

  // Hold control state and the output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r        <= 1'b0;
      s2_r        <= 1'b0;
      phase_r     <= PH_COUNT;
      cnt_r       <= '0;
      rem_r       <= '0;
      nodes_r     <= '0;
      top_r       <= '0;
      leaf_wait_r <= '0;
      walk_r      <= '0;
      last_int_r  <= 1'b0;
      at_root_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      s1_r        <= s1_nxt;
      s2_r        <= s2_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      nodes_r     <= nodes_nxt;
      top_r       <= top_nxt;
      leaf_wait_r <= leaf_wait_nxt;
      walk_r      <= walk_nxt;
      last_int_r  <= last_int_nxt;
      at_root_r   <= at_root_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: captured beat, walk node, result beat
  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_beat;
    end
    cur_r      <= cur_nxt;
    out_beat_r <= out_beat_nxt;
  end

endmodule : huffman_stream_decoder
`default_nettype wire
